### rtl/core/pnps_pkg.sv
`timescale 1ns / 1ps

package pnps_pkg;

	localparam int COORD_BITS = 24;
	localparam int IDX_FIELD_W = 10;
	localparam int DIST_W = 52;
	localparam int CNT_REG_W = 11;
	localparam int TOL_W = 32;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_MAX_POINTS = 1024;
	localparam int CELL_COUNT = 2;
	localparam int CELL_BITS = 1;

	// Squares of magnitudes at or above 2^SAT_SHIFT saturate
	localparam int SAT_SHIFT = 26;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [CNT_REG_W-1:0] POINT_COUNT_RST = CNT_REG_W'(1);
	localparam logic [TOL_W-1:0] STOP_TOL_RST = TOL_W'(1678);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_STOP_TOL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic operation;
		logic [IDX_FIELD_W-1:0] entry_index;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} item_t;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0] nearest_index;
		logic [DIST_W-1:0] min_distance_sq;
		logic stopped_early;
	} result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_ctl_t;

endpackage

### rtl/core/path_nearest_point_search_top.sv
`timescale 1ns / 1ps

// Nearest path point search by squared Euclidean distance.
// Command channel: a transaction is taken on a rising edge with start high and
// busy low. A load transaction (operation = load) writes one point into the
// table in that same edge and keeps busy low; it returns nothing. A query
// transaction raises busy and scans entries 0 to point_count-1.
// Result channel: done is high for exactly one cycle with the result on the
// result port; the receiver cannot stall it, so capture it on that edge.
// Query scan: one entry is read from the banked table per cycle until n
// entries are scanned (at most MAX_POINTS) or the scan stops early. Each read
// passes through the two-cell bank row and then the three-stage distance
// unit before it reaches the compare. After an early stop busy stays high
// while scans already in flight drain away.
// Configuration: cfg_we writes cfg_data into register cfg_index on the edge;
// write only while busy is low. Reset clears the control state and sets
// point_count to 1 and stop_tolerance to 1678; the table holds no valid data
// until loaded.
module path_nearest_point_search_top #(
	parameter int MAX_POINTS = pnps_pkg::DEF_MAX_POINTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pnps_pkg::item_t                   item,
	output logic                              done,
	output pnps_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pnps_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int BANK_DEPTH =
		(MAX_POINTS + pnps_pkg::CELL_COUNT - 1) / pnps_pkg::CELL_COUNT;
	localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	// Register stages from issue of a read to its distance reaching the compare
	localparam int PIPE_LAT = pnps_pkg::CELL_COUNT + 3;
	localparam int DRAIN_W = $clog2(PIPE_LAT + 1);
	localparam int DIST_W = pnps_pkg::DIST_W;

	pnps_pkg::state_t state_q;
	pnps_pkg::state_t state_d;

	logic [pnps_pkg::CNT_REG_W-1:0] point_count_q;
	logic [pnps_pkg::TOL_W-1:0] stop_tol_q;

	logic issue_on_q;
	logic [IDX_W-1:0] issue_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DRAIN_W-1:0] drain_cnt_q;
	pnps_pkg::point_t qry_q;

	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic done_q;
	pnps_pkg::result_t result_q;

	logic accept;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	pnps_pkg::point_t wr_pt;
	logic [CNT_W-1:0] eff_cnt;
	logic issue_last;

	pnps_pkg::scan_ctl_t chain_ctl [pnps_pkg::CELL_COUNT + 1];
	logic [IDX_W-1:0] chain_idx [pnps_pkg::CELL_COUNT + 1];
	pnps_pkg::point_t chain_pt [pnps_pkg::CELL_COUNT + 1];

	pnps_pkg::scan_ctl_t fin_ctl;
	logic [IDX_W-1:0] fin_idx;
	logic [DIST_W-1:0] fin_dist;

	logic scan_hit;
	logic cand_better;
	logic [DIST_W-1:0] cand_best;
	logic [IDX_W-1:0] cand_idx;
	logic cand_stop;
	logic scan_end;

	assign busy = (state_q != pnps_pkg::ST_IDLE);
	assign accept = start && (state_q == pnps_pkg::ST_IDLE);

	// Loads aimed beyond the table are dropped
	assign wr_en = accept && (item.operation == pnps_pkg::OP_LOAD) &&
		(32'(item.entry_index) < 32'(MAX_POINTS));
	assign wr_idx = IDX_W'(item.entry_index);
	assign wr_pt.x = item.coord_x;
	assign wr_pt.y = item.coord_y;

	// Zero scans one entry; anything above the table size scans it all
	always_comb begin
		if (point_count_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			eff_cnt = CNT_W'(MAX_POINTS);
		end else begin
			eff_cnt = CNT_W'(point_count_q);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= pnps_pkg::POINT_COUNT_RST;
			stop_tol_q <= pnps_pkg::STOP_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pnps_pkg::REG_POINT_COUNT: begin
					point_count_q <= pnps_pkg::CNT_REG_W'(cfg_data);
				end
				pnps_pkg::REG_STOP_TOL: begin
					stop_tol_q <= pnps_pkg::TOL_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Read issue: one entry index per cycle into the head of the bank row
	assign issue_last = (CNT_W'(issue_idx_q) + CNT_W'(1)) == cnt_q;
	assign chain_ctl[0].valid = (state_q == pnps_pkg::ST_SCAN) && issue_on_q;
	assign chain_ctl[0].first = (issue_idx_q == '0);
	assign chain_ctl[0].last = issue_last;
	assign chain_idx[0] = issue_idx_q;
	assign chain_pt[0] = '0;

	genvar g;
	generate
		for (g = 0; g < pnps_pkg::CELL_COUNT; g++) begin : g_cell
			pnps_cell #(
				.IDX_W      (IDX_W),
				.BANK_DEPTH (BANK_DEPTH),
				.BANK_AW    (BANK_AW),
				.CELL_ID    (g)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr_en   (wr_en),
				.wr_idx  (wr_idx),
				.wr_pt   (wr_pt),
				.in_ctl  (chain_ctl[g]),
				.in_idx  (chain_idx[g]),
				.in_pt   (chain_pt[g]),
				.out_ctl (chain_ctl[g + 1]),
				.out_idx (chain_idx[g + 1]),
				.out_pt  (chain_pt[g + 1])
			);
		end
	endgenerate

	pnps_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (chain_ctl[pnps_pkg::CELL_COUNT]),
		.in_idx   (chain_idx[pnps_pkg::CELL_COUNT]),
		.in_pt    (chain_pt[pnps_pkg::CELL_COUNT]),
		.qry_pt   (qry_q),
		.out_ctl  (fin_ctl),
		.out_idx  (fin_idx),
		.out_dist (fin_dist)
	);

	// Running minimum: keep the first strictly smaller distance, stop once the
	// minimum is at or below the tolerance. Distances arriving outside a scan
	// are leftovers of an early stop and are dropped.
	assign scan_hit = (state_q == pnps_pkg::ST_SCAN) && fin_ctl.valid;
	assign cand_better = fin_ctl.first || (fin_dist < best_q);
	assign cand_best = cand_better ? fin_dist : best_q;
	assign cand_idx = cand_better ? fin_idx : best_idx_q;
	assign cand_stop = cand_best <= DIST_W'(stop_tol_q);
	assign scan_end = scan_hit && (cand_stop || fin_ctl.last);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pnps_pkg::ST_IDLE: begin
				if (accept && (item.operation == pnps_pkg::OP_QUERY)) begin
					state_d = pnps_pkg::ST_SCAN;
				end
			end
			pnps_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = fin_ctl.last ? pnps_pkg::ST_IDLE : pnps_pkg::ST_DRAIN;
				end
			end
			pnps_pkg::ST_DRAIN: begin
				if (drain_cnt_q == '0) begin
					state_d = pnps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pnps_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Issue counter and drain timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_on_q <= 1'b0;
			issue_idx_q <= '0;
			cnt_q <= '0;
			drain_cnt_q <= '0;
		end else begin
			if (accept && (item.operation == pnps_pkg::OP_QUERY)) begin
				issue_on_q <= 1'b1;
				issue_idx_q <= '0;
				cnt_q <= eff_cnt;
			end else if (scan_hit && cand_stop) begin
				issue_on_q <= 1'b0;
			end else if (chain_ctl[0].valid) begin
				if (issue_last) begin
					issue_on_q <= 1'b0;
				end else begin
					issue_idx_q <= issue_idx_q + IDX_W'(1);
				end
			end

			if (scan_end && !fin_ctl.last) begin
				drain_cnt_q <= DRAIN_W'(PIPE_LAT - 1);
			end else if ((state_q == pnps_pkg::ST_DRAIN) && (drain_cnt_q != '0)) begin
				drain_cnt_q <= drain_cnt_q - DRAIN_W'(1);
			end
		end
	end

	// Query position, running minimum and result payload
	always_ff @(posedge clk) begin
		if (accept && (item.operation == pnps_pkg::OP_QUERY)) begin
			qry_q.x <= item.coord_x;
			qry_q.y <= item.coord_y;
		end
		if (scan_hit) begin
			best_q <= cand_best;
			best_idx_q <= cand_idx;
		end
		if (scan_end) begin
			result_q.nearest_index <= pnps_pkg::IDX_FIELD_W'(cand_idx);
			result_q.min_distance_sq <= cand_best;
			result_q.stopped_early <= cand_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= scan_end;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

### rtl/core/pnps_cell.sv
`timescale 1ns / 1ps

// One bank of the point table. The read request walks along the row; the cell
// that owns the entry swaps its read data in, the others pass the neighbour's on.
module pnps_cell #(
	parameter int IDX_W = 10,
	parameter int BANK_DEPTH = 512,
	parameter int BANK_AW = 9,
	parameter int CELL_ID = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  pnps_pkg::point_t      wr_pt,
	input  pnps_pkg::scan_ctl_t   in_ctl,
	input  logic [IDX_W-1:0]      in_idx,
	input  pnps_pkg::point_t      in_pt,
	output pnps_pkg::scan_ctl_t   out_ctl,
	output logic [IDX_W-1:0]      out_idx,
	output pnps_pkg::point_t      out_pt
);

	pnps_pkg::point_t mem [BANK_DEPTH];
	pnps_pkg::point_t rd_q;
	pnps_pkg::point_t pt_q;
	pnps_pkg::scan_ctl_t ctl_q;
	logic [IDX_W-1:0] idx_q;
	logic hit_q;

	logic wr_hit;
	logic rd_hit;
	logic [BANK_AW-1:0] wr_addr;
	logic [BANK_AW-1:0] rd_addr;

	assign wr_hit = wr_en &&
		(wr_idx[pnps_pkg::CELL_BITS-1:0] == pnps_pkg::CELL_BITS'(CELL_ID));
	assign rd_hit = in_idx[pnps_pkg::CELL_BITS-1:0] == pnps_pkg::CELL_BITS'(CELL_ID);
	assign wr_addr = BANK_AW'(wr_idx >> pnps_pkg::CELL_BITS);
	assign rd_addr = BANK_AW'(in_idx >> pnps_pkg::CELL_BITS);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_addr] <= wr_pt;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		pt_q <= in_pt;
		idx_q <= in_idx;
		hit_q <= rd_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= in_ctl;
		end
	end

	assign out_ctl = ctl_q;
	assign out_idx = idx_q;
	assign out_pt = hit_q ? rd_q : pt_q;

endmodule

### rtl/core/pnps_dist.sv
`timescale 1ns / 1ps

// Squared distance in three stages: difference and magnitude, square, sum.
module pnps_dist #(
	parameter int IDX_W = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pnps_pkg::scan_ctl_t               in_ctl,
	input  logic [IDX_W-1:0]                  in_idx,
	input  pnps_pkg::point_t                  in_pt,
	input  pnps_pkg::point_t                  qry_pt,
	output pnps_pkg::scan_ctl_t               out_ctl,
	output logic [IDX_W-1:0]                  out_idx,
	output logic [pnps_pkg::DIST_W-1:0]       out_dist
);

	localparam int DIFF_W = pnps_pkg::COORD_BITS + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int DIST_W = pnps_pkg::DIST_W;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0] mag_x;
	logic [DIFF_W-1:0] mag_y;
	logic [SQ_W-1:0] sq_x;
	logic [SQ_W-1:0] sq_y;
	logic [DIST_W:0] sum;

	logic [DIFF_W-1:0] mag_x_s1;
	logic [DIFF_W-1:0] mag_y_s1;
	logic [DIST_W-1:0] sq_x_s2;
	logic [DIST_W-1:0] sq_y_s2;
	logic [DIST_W-1:0] dist_s3;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] idx_s2;
	logic [IDX_W-1:0] idx_s3;
	pnps_pkg::scan_ctl_t ctl_s1;
	pnps_pkg::scan_ctl_t ctl_s2;
	pnps_pkg::scan_ctl_t ctl_s3;

	assign dx = DIFF_W'(in_pt.x) - DIFF_W'(qry_pt.x);
	assign dy = DIFF_W'(in_pt.y) - DIFF_W'(qry_pt.y);
	assign mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	assign sq_x = mag_x_s1 * mag_x_s1;
	assign sq_y = mag_y_s1 * mag_y_s1;

	assign sum = (DIST_W + 1)'(sq_x_s2) + (DIST_W + 1)'(sq_y_s2);

	always_ff @(posedge clk) begin
		mag_x_s1 <= mag_x;
		mag_y_s1 <= mag_y;
		idx_s1 <= in_idx;
		sq_x_s2 <= ((mag_x_s1 >> pnps_pkg::SAT_SHIFT) != '0) ?
			pnps_pkg::DIST_MAX : DIST_W'(sq_x);
		sq_y_s2 <= ((mag_y_s1 >> pnps_pkg::SAT_SHIFT) != '0) ?
			pnps_pkg::DIST_MAX : DIST_W'(sq_y);
		idx_s2 <= idx_s1;
		dist_s3 <= sum[DIST_W] ? pnps_pkg::DIST_MAX : sum[DIST_W-1:0];
		idx_s3 <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign out_ctl = ctl_s3;
	assign out_idx = idx_s3;
	assign out_dist = dist_s3;

endmodule
